/* design/kut_pkg.sv */
// Shared types, codes and the vocabulary lookup for the kana UTF-8 tokenizer.
package kut_pkg;

    localparam int unsigned IdW  = 7;
    localparam int unsigned StW  = 3;
    localparam int unsigned LenW = 16;
    localparam int unsigned CpW  = 16;

    // status codes
    localparam logic [StW-1:0] ST_OK       = 3'd0;
    localparam logic [StW-1:0] ST_BAD_UTF8 = 3'd1;
    localparam logic [StW-1:0] ST_UNKNOWN  = 3'd2;
    localparam logic [StW-1:0] ST_OVER_CAP = 3'd3;
    localparam logic [StW-1:0] ST_EMPTY    = 3'd4;

    // special token ids
    localparam logic [IdW-1:0] TOK_NONE  = 7'd0;
    localparam logic [IdW-1:0] TOK_BEGIN = 7'd1;
    localparam logic [IdW-1:0] TOK_END   = 7'd2;

    // code points
    localparam logic [CpW-1:0] CP_HIRA_LO   = 16'h3041;
    localparam logic [CpW-1:0] CP_HIRA_HI   = 16'h3096;
    localparam logic [CpW-1:0] CP_KATA_LO   = 16'h30a1;
    localparam logic [CpW-1:0] CP_KATA_HI   = 16'h30f6;
    localparam logic [CpW-1:0] CP_KATA_OFS  = 16'h0060;
    localparam logic [CpW-1:0] CP_LONG_MARK = 16'h30fc;
    localparam logic [CpW-1:0] CP_FULL_STOP = 16'h3002;
    localparam logic [CpW-1:0] CP_COMMA     = 16'h3001;
    localparam logic [CpW-1:0] CP_FW_EXCL   = 16'hff01;
    localparam logic [CpW-1:0] CP_FW_QUEST  = 16'hff1f;
    localparam logic [CpW-1:0] CP_IDEO_SP   = 16'h3000;
    localparam logic [CpW-1:0] CP_SURR_LO   = 16'hd800;
    localparam logic [CpW-1:0] CP_SURR_HI   = 16'hdfff;
    localparam logic [CpW-1:0] CP_MIN_3B    = 16'h0800;

    // the first hiragana code point (CP_HIRA_LO) maps to id 5
    localparam logic [CpW-1:0] CP_HIRA_BASE = CP_HIRA_LO - 16'd5;

    typedef struct packed {
        logic [IdW-1:0]  token_id;
        logic [StW-1:0]  status;
        logic            seq_end;
        logic [LenW-1:0] seq_len;
    } res_t;

    // vocabulary id of a code point, 0 when it has none
    function automatic logic [IdW-1:0] vocab_id(input logic [CpW-1:0] cp_in);
        logic [CpW-1:0] cp;
        logic [CpW-1:0] ofs;
        logic [IdW-1:0] id;
        cp  = cp_in;
        ofs = '0;
        id  = TOK_NONE;
        if (cp inside {[CP_KATA_LO:CP_KATA_HI]})
            cp = cp - CP_KATA_OFS;
        if (cp inside {[CP_HIRA_LO:CP_HIRA_HI]})
        begin
            ofs = cp - CP_HIRA_BASE;
            id  = ofs[IdW-1:0];
        end
        else if (cp == CP_LONG_MARK) id = 7'd91;
        else if (cp == CP_FULL_STOP) id = 7'd92;
        else if (cp == CP_COMMA)     id = 7'd93;
        else if (cp == CP_FW_EXCL)   id = 7'd94;
        else if (cp == CP_FW_QUEST)  id = 7'd95;
        else if (cp inside {[16'h0030:16'h0039]})
        begin
            ofs = cp + 16'd48;   // '0' (0x30) -> 96
            id  = ofs[IdW-1:0];
        end
        return id;
    endfunction

endpackage

/* design/kana_utf8_tokenizer.sv */
// Top level of the kana UTF-8 tokenizer: byte decode, vocabulary map, result queue.
//
//  channel | signals                                   | dir | transfer when
//  --------+-------------------------------------------+-----+-----------------------
//  in      | in_valid, in_ready, text_byte, terminator | in  | in_valid & in_ready
//  out     | out_valid, out_ready, token_id, status,   | out | out_valid & out_ready
//          | sequence_end, sequence_length             |     |
//  cfg     | cfg_write_en, cfg_write_data (max_ids)    | in  | cfg_write_en
//
// One input byte per cycle while in_ready is high. Each accepted byte is decoded
// in the cycle of its transfer and its results (zero, one or, for the first byte
// of a text, two) go into a four-entry result queue; outputs come straight from
// queue storage. in_ready is high while the queue has room for two results. With
// out_ready held high a byte goes in every cycle, except that the begin token adds
// one result per text, so once the queue backs up a new text can bring in_ready
// low (one result leaves per cycle).
// Reset (rst_n low, async) empties the queue, closes any open text and sets
// max_ids to 256. A stall on out only backs up the queue.
module kana_utf8_tokenizer
    import kut_pkg::*;
#(
    parameter int unsigned VOCAB_SIZE = 128
)(
    input  logic            clk,
    input  logic            rst_n,
    // configuration
    input  logic            cfg_write_en,
    input  logic [15:0]     cfg_write_data,
    // byte input
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      text_byte,
    input  logic            terminator,
    // token output
    output logic            out_valid,
    input  logic            out_ready,
    output logic [IdW-1:0]  token_id,
    output logic [StW-1:0]  status,
    output logic            sequence_end,
    output logic [LenW-1:0] sequence_length
);

    localparam int unsigned QDepth = 4;
    localparam int unsigned QPtrW  = $clog2(QDepth);
    localparam int unsigned QCntW  = $clog2(QDepth + 1);

    // ---------------- state ----------------
    logic [15:0]     max_ids_reg;
    logic            started_reg,  started_next;
    logic            failed_reg,   failed_next;
    logic [1:0]      pend_reg,     pend_next;
    logic [3:0]      lead_reg,     lead_next;
    logic [5:0]      mid_reg,      mid_next;
    logic [LenW-1:0] cnt_reg,      cnt_next;

    res_t             q_mem [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0] q_cnt_reg,  q_cnt_next;

    // ---------------- handshake ----------------
    logic in_xfer;
    logic out_xfer;

    assign in_ready  = (q_cnt_reg <= QCntW'(QDepth - 2));
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = (q_cnt_reg != '0);
    assign out_xfer  = out_valid && out_ready;

    // ---------------- decode ----------------
    logic [15:0]     cap;
    logic [15:0]     cap_m1;
    logic [LenW-1:0] cnt0;        // id count once the begin token is counted
    logic            is_cont;
    logic [CpW-1:0]  cp;
    logic            have;
    logic [StW-1:0]  st;
    logic [IdW-1:0]  char_id;
    logic            char_ok;
    logic            emit_begin;
    logic            emit_main;
    res_t            main_res;
    res_t            begin_res;
    res_t            wr0, wr1;
    logic [1:0]      push_n;

    assign cap     = (max_ids_reg < 16'd3) ? 16'd3 : max_ids_reg;
    assign cap_m1  = cap - 16'd1;
    assign is_cont = (text_byte[7:6] == 2'b10);
    assign cnt0    = started_reg ? cnt_reg : LenW'(1);

    // lookup, with ids past the vocabulary treated as unknown
    always_comb
    begin
        char_id = vocab_id(cp);
        char_ok = (char_id != TOK_NONE) && ({1'b0, char_id} < 8'(VOCAB_SIZE));
    end

    assign begin_res = '{token_id: TOK_BEGIN, status: ST_OK, seq_end: 1'b0, seq_len: '0};

    always_comb
    begin
        started_next = started_reg;
        failed_next  = failed_reg;
        pend_next    = pend_reg;
        lead_next    = lead_reg;
        mid_next     = mid_reg;
        cnt_next     = cnt_reg;
        cp           = '0;
        have         = 1'b0;
        st           = ST_OK;
        emit_begin   = 1'b0;
        emit_main    = 1'b0;
        main_res     = '{token_id: TOK_NONE, status: ST_OK, seq_end: 1'b0, seq_len: '0};

        if (in_xfer)
        begin
            if (failed_reg)
            begin
                // discard until the terminator closes the text
                if (terminator)
                begin
                    started_next = 1'b0;
                    failed_next  = 1'b0;
                    pend_next    = '0;
                    lead_next    = '0;
                    mid_next     = '0;
                    cnt_next     = '0;
                end
            end
            else
            begin
                emit_begin   = !started_reg;
                started_next = 1'b1;
                cnt_next     = cnt0;
                if (terminator)
                begin
                    emit_main        = 1'b1;
                    main_res.seq_end = 1'b1;
                    main_res.seq_len = cnt0;
                    if (pend_reg != 2'd0 && started_reg)
                        main_res.status = ST_BAD_UTF8;
                    else if (cnt0 <= LenW'(1))
                        main_res.status = ST_EMPTY;
                    else
                    begin
                        main_res.token_id = TOK_END;
                        main_res.seq_len  = cnt0 + LenW'(1);
                    end
                    started_next = 1'b0;
                    failed_next  = 1'b0;
                    pend_next    = '0;
                    lead_next    = '0;
                    mid_next     = '0;
                    cnt_next     = '0;
                end
                else
                begin
                    if (started_reg && pend_reg == 2'd2)
                    begin
                        if (!is_cont)
                            st = ST_BAD_UTF8;
                        else
                        begin
                            mid_next  = text_byte[5:0];
                            pend_next = 2'd1;
                        end
                    end
                    else if (started_reg && pend_reg == 2'd1)
                    begin
                        pend_next = 2'd0;
                        if (!is_cont)
                            st = ST_BAD_UTF8;
                        else
                        begin
                            cp = {lead_reg, mid_reg, text_byte[5:0]};
                            if (cp < CP_MIN_3B || cp inside {[CP_SURR_LO:CP_SURR_HI]})
                                st = ST_BAD_UTF8;
                            else
                                have = (cp != CP_IDEO_SP);
                        end
                    end
                    else
                    begin
                        pend_next = 2'd0;
                        if (!text_byte[7])
                        begin
                            // ASCII; fold ? and ! to fullwidth
                            case (text_byte)
                                8'h3f:   cp = CP_FW_QUEST;
                                8'h21:   cp = CP_FW_EXCL;
                                default: cp = {8'h00, text_byte};
                            endcase
                            have = !(text_byte == 8'h20 || text_byte == 8'h09);
                        end
                        else if (text_byte inside {[8'he0:8'hef]})
                        begin
                            lead_next = text_byte[3:0];
                            pend_next = 2'd2;
                        end
                        else
                            st = ST_BAD_UTF8;
                    end

                    if (st == ST_OK && have)
                    begin
                        if (!char_ok)
                            st = ST_UNKNOWN;
                        else if (cnt0 >= cap_m1)
                            st = ST_OVER_CAP;
                        else
                        begin
                            cnt_next          = cnt0 + LenW'(1);
                            emit_main         = 1'b1;
                            main_res.token_id = char_id;
                        end
                    end

                    if (st != ST_OK)
                    begin
                        emit_main        = 1'b1;
                        main_res.status  = st;
                        main_res.seq_end = 1'b1;
                        main_res.seq_len = cnt0;
                        failed_next      = 1'b1;
                        pend_next        = '0;
                    end
                end
            end
        end
    end

    // ---------------- result queue ----------------
    always_comb
    begin
        push_n = {1'b0, emit_begin} + {1'b0, emit_main};
        wr0    = emit_begin ? begin_res : main_res;
        wr1    = main_res;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPtrW'(push_n);
        rd_ptr_next = rd_ptr_reg + QPtrW'(out_xfer);
        q_cnt_next  = q_cnt_reg + QCntW'(push_n) - QCntW'(out_xfer);
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            q_mem[wr_ptr_reg] <= wr0;
        if (push_n == 2'd2)
            q_mem[wr_ptr_reg + QPtrW'(1)] <= wr1;
    end

    assign token_id        = q_mem[rd_ptr_reg].token_id;
    assign status          = q_mem[rd_ptr_reg].status;
    assign sequence_end    = q_mem[rd_ptr_reg].seq_end;
    assign sequence_length = q_mem[rd_ptr_reg].seq_len;

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_ids_reg <= 16'd256;
            started_reg <= 1'b0;
            failed_reg  <= 1'b0;
            pend_reg    <= '0;
            lead_reg    <= '0;
            mid_reg     <= '0;
            cnt_reg     <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_write_en)
                max_ids_reg <= cfg_write_data;
            started_reg <= started_next;
            failed_reg  <= failed_next;
            pend_reg    <= pend_next;
            lead_reg    <= lead_next;
            mid_reg     <= mid_next;
            cnt_reg     <= cnt_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            q_cnt_reg   <= q_cnt_next;
        end
    end

    // ---------------- assertions ----------------
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= QCntW'(QDepth))
        else $error("result queue overfilled");

    a_two_only_at_begin: assert property (@(posedge clk) disable iff (!rst_n)
        push_n == 2'd2 |-> (in_xfer && !started_reg && !failed_reg))
        else $error("two results from a byte that did not open a text");

    a_quiet_when_failed: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && failed_reg) |-> push_n == 2'd0)
        else $error("result produced while discarding");

    a_term_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && terminator) |=> (!started_reg && !failed_reg && cnt_reg == '0))
        else $error("text not closed after terminator");

endmodule
